// File: rtl/triangle_shared_edge_detect_assert.svh
// assertion macros for the triangle shared edge detector
`ifndef TRIANGLE_SHARED_EDGE_DETECT_ASSERT_SVH
`define TRIANGLE_SHARED_EDGE_DETECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsed assertion failed");
`define TSED_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `TSED_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define TSED_ASSERT(lbl, clk, rst_n, prop)
`define TSED_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/tsed_pkg.sv
package tsed_pkg;

    localparam int COORD_BITS = 16;
    localparam int VERT_W     = 48;
    localparam int PACK_W     = 3 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int SUM_W      = 2 * COORD_BITS + 2;
    localparam int NSTEP      = COORD_BITS + 1;
    localparam int DIST_W     = 17;

    typedef enum logic [1:0] {
        EDGE_V0V1 = 2'd0,
        EDGE_V1V2 = 2'd1,
        EDGE_V2V0 = 2'd2
    } t_edge;

    typedef struct packed {
        logic              adj;
        t_edge             first_edge;
        t_edge             second_edge;
        logic [VERT_W-1:0] first_mid;
        logic [VERT_W-1:0] second_mid;
    } t_side;

    function automatic t_edge edge_of(input logic [1:0] a, input logic [1:0] b);
        t_edge e;
        if ((a == 2'd0 && b == 2'd1) || (a == 2'd1 && b == 2'd0)) begin
            e = EDGE_V0V1;
        end else if ((a == 2'd1 && b == 2'd2) || (a == 2'd2 && b == 2'd1)) begin
            e = EDGE_V1V2;
        end else begin
            e = EDGE_V2V0;
        end
        return e;
    endfunction

endpackage

// File: rtl/tsed_front.sv
module tsed_front (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [tsed_pkg::VERT_W-1:0]                i_p0,
    input  logic [tsed_pkg::VERT_W-1:0]                i_p1,
    input  logic [tsed_pkg::VERT_W-1:0]                i_p2,
    input  logic [tsed_pkg::VERT_W-1:0]                i_q0,
    input  logic [tsed_pkg::VERT_W-1:0]                i_q1,
    input  logic [tsed_pkg::VERT_W-1:0]                i_q2,
    input  logic [tsed_pkg::VERT_W-1:0]                i_c1,
    input  logic [tsed_pkg::VERT_W-1:0]                i_c2,
    output logic                                       o_valid,
    output tsed_pkg::t_side                            o_side,
    output logic [2:0][tsed_pkg::DIFF_W-1:0]           o_diff
);

    localparam int C = tsed_pkg::COORD_BITS;

    function automatic logic [tsed_pkg::PACK_W-1:0] pick(
        input logic [1:0]                  sel,
        input logic [tsed_pkg::PACK_W-1:0] a,
        input logic [tsed_pkg::PACK_W-1:0] b,
        input logic [tsed_pkg::PACK_W-1:0] c
    );
        logic [tsed_pkg::PACK_W-1:0] r;
        case (sel)
            2'd0:    r = a;
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [tsed_pkg::VERT_W-1:0] midpoint(
        input logic [tsed_pkg::PACK_W-1:0] a,
        input logic [tsed_pkg::PACK_W-1:0] b
    );
        logic [tsed_pkg::VERT_W-1:0] r;
        logic [C:0]                  s;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s = {a[k*C + C - 1], a[k*C +: C]} + {b[k*C + C - 1], b[k*C +: C]};
            r[k*C +: C] = s[C:1];
        end
        return r;
    endfunction

    logic [2:0][tsed_pkg::PACK_W-1:0] p;
    logic [2:0][tsed_pkg::PACK_W-1:0] q;
    logic [2:0][2:0]                  eq;
    logic                             have1;
    logic                             adj;
    logic                             found;
    logic [1:0]                       f1, s1, f2, s2;
    tsed_pkg::t_side                  n_side;
    logic [2:0][tsed_pkg::DIFF_W-1:0] n_diff;
    logic                             r_valid;
    tsed_pkg::t_side                  r_side;
    logic [2:0][tsed_pkg::DIFF_W-1:0] r_diff;

    assign p = {i_p2[tsed_pkg::PACK_W-1:0], i_p1[tsed_pkg::PACK_W-1:0],
                i_p0[tsed_pkg::PACK_W-1:0]};
    assign q = {i_q2[tsed_pkg::PACK_W-1:0], i_q1[tsed_pkg::PACK_W-1:0],
                i_q0[tsed_pkg::PACK_W-1:0]};

    // ordered scan, each first vertex claims the first free match
    always_comb begin
        have1 = 1'b0;
        adj   = 1'b0;
        found = 1'b0;
        f1    = 2'd0;
        s1    = 2'd0;
        f2    = 2'd0;
        s2    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                eq[i][j] = (p[i] == q[j]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            found = 1'b0;
            if (!adj) begin
                for (int j = 0; j < 3; j++) begin
                    if (!found && !(have1 && s1 == 2'(j)) && eq[i][j]) begin
                        found = 1'b1;
                        if (have1) begin
                            f2  = 2'(i);
                            s2  = 2'(j);
                            adj = 1'b1;
                        end else begin
                            f1    = 2'(i);
                            s1    = 2'(j);
                            have1 = 1'b1;
                        end
                    end
                end
            end
        end
        n_side = '0;
        if (adj) begin
            n_side.adj         = 1'b1;
            n_side.first_edge  = tsed_pkg::edge_of(f1, f2);
            n_side.second_edge = tsed_pkg::edge_of(s1, s2);
            n_side.first_mid   = midpoint(pick(f1, p[0], p[1], p[2]),
                                          pick(f2, p[0], p[1], p[2]));
            n_side.second_mid  = midpoint(pick(s1, q[0], q[1], q[2]),
                                          pick(s2, q[0], q[1], q[2]));
        end
        for (int k = 0; k < 3; k++) begin
            n_diff[k] = {i_c1[k*C + C - 1], i_c1[k*C +: C]}
                      - {i_c2[k*C + C - 1], i_c2[k*C +: C]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_diff <= n_diff;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_diff  = r_diff;

endmodule

// File: rtl/tsed_sqrt_cell.sv
module tsed_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [tsed_pkg::SUM_W-1:0]   i_rem,
    input  logic [tsed_pkg::SUM_W-1:0]   i_root,
    input  tsed_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [tsed_pkg::SUM_W-1:0]   o_rem,
    output logic [tsed_pkg::SUM_W-1:0]   o_root,
    output tsed_pkg::t_side              o_side
);

    localparam logic [tsed_pkg::SUM_W-1:0] BIT = tsed_pkg::SUM_W'(1) << BIT_POS;

    logic [tsed_pkg::SUM_W-1:0] trial;
    logic [tsed_pkg::SUM_W-1:0] n_rem;
    logic [tsed_pkg::SUM_W-1:0] n_root;
    logic                       r_valid;
    logic [tsed_pkg::SUM_W-1:0] r_rem;
    logic [tsed_pkg::SUM_W-1:0] r_root;
    tsed_pkg::t_side            r_side;

    // one restoring square root digit
    always_comb begin
        trial = i_root + BIT;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// File: rtl/triangle_shared_edge_detect.sv
// path: front, square and sum stages, then the 17-cell square root chain to o_valid
// throughput: one transaction per cycle, the whole pipeline holds while o_valid waits
// reset: synchronous active low, clears every stage valid bit, payload is not reset
`include "triangle_shared_edge_detect_assert.svh"
module triangle_shared_edge_detect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tsed_pkg::VERT_W-1:0]       i_first_vertex0,
    input  logic [tsed_pkg::VERT_W-1:0]       i_first_vertex1,
    input  logic [tsed_pkg::VERT_W-1:0]       i_first_vertex2,
    input  logic [tsed_pkg::VERT_W-1:0]       i_second_vertex0,
    input  logic [tsed_pkg::VERT_W-1:0]       i_second_vertex1,
    input  logic [tsed_pkg::VERT_W-1:0]       i_second_vertex2,
    input  logic [tsed_pkg::VERT_W-1:0]       i_first_center,
    input  logic [tsed_pkg::VERT_W-1:0]       i_second_center,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_adjacent,
    output logic [1:0]                        o_first_edge,
    output logic [1:0]                        o_second_edge,
    output logic [tsed_pkg::DIST_W-1:0]       o_center_distance,
    output logic [tsed_pkg::VERT_W-1:0]       o_first_edge_midpoint,
    output logic [tsed_pkg::VERT_W-1:0]       o_second_edge_midpoint
);

    localparam int NSTEP = tsed_pkg::NSTEP;

    logic                                en;
    logic                                a_valid;
    tsed_pkg::t_side                     a_side;
    logic [2:0][tsed_pkg::DIFF_W-1:0]    a_diff;
    logic [2:0][2*tsed_pkg::DIFF_W-1:0]  n_sq;
    logic [tsed_pkg::SUM_W-1:0]          n_sum;
    logic                                r_b_valid;
    tsed_pkg::t_side                     r_b_side;
    logic [2:0][tsed_pkg::SQ_W-1:0]      r_b_sq;
    logic                                r_c_valid;
    tsed_pkg::t_side                     r_c_side;
    logic [tsed_pkg::SUM_W-1:0]          r_c_sum;
    logic [NSTEP:0]                      ch_valid;
    logic [tsed_pkg::SUM_W-1:0]          ch_rem  [NSTEP+1];
    logic [tsed_pkg::SUM_W-1:0]          ch_root [NSTEP+1];
    tsed_pkg::t_side                     ch_side [NSTEP+1];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    tsed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_p0    (i_first_vertex0),
        .i_p1    (i_first_vertex1),
        .i_p2    (i_first_vertex2),
        .i_q0    (i_second_vertex0),
        .i_q1    (i_second_vertex1),
        .i_q2    (i_second_vertex2),
        .i_c1    (i_first_center),
        .i_c2    (i_second_center),
        .o_valid (a_valid),
        .o_side  (a_side),
        .o_diff  (a_diff)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sq[k] = $signed(a_diff[k]) * $signed(a_diff[k]);
        end
        n_sum = tsed_pkg::SUM_W'(r_b_sq[0]) + tsed_pkg::SUM_W'(r_b_sq[1])
              + tsed_pkg::SUM_W'(r_b_sq[2]);
        if (!r_b_side.adj) begin
            n_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side <= a_side;
            for (int k = 0; k < 3; k++) begin
                r_b_sq[k] <= n_sq[k][tsed_pkg::SQ_W-1:0];
            end
            r_c_side <= r_b_side;
            r_c_sum  <= n_sum;
        end
    end

    assign ch_valid[0] = r_c_valid;
    assign ch_rem[0]   = r_c_sum;
    assign ch_root[0]  = '0;
    assign ch_side[0]  = r_c_side;

    for (genvar k = 0; k < NSTEP; k++) begin : g_cell
        tsed_sqrt_cell #(
            .BIT_POS (2 * (NSTEP - 1 - k))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[k]),
            .i_rem   (ch_rem[k]),
            .i_root  (ch_root[k]),
            .i_side  (ch_side[k]),
            .o_valid (ch_valid[k+1]),
            .o_rem   (ch_rem[k+1]),
            .o_root  (ch_root[k+1]),
            .o_side  (ch_side[k+1])
        );
    end

    assign o_valid                = ch_valid[NSTEP];
    assign o_adjacent             = ch_side[NSTEP].adj;
    assign o_first_edge           = ch_side[NSTEP].first_edge;
    assign o_second_edge          = ch_side[NSTEP].second_edge;
    assign o_center_distance      = ch_root[NSTEP][tsed_pkg::DIST_W-1:0];
    assign o_first_edge_midpoint  = ch_side[NSTEP].first_mid;
    assign o_second_edge_midpoint = ch_side[NSTEP].second_mid;

    `TSED_ASSERT(a_not_adj_zero, i_clk, i_rst_n, o_valid && !o_adjacent |-> o_center_distance == '0 && o_first_edge_midpoint == '0 && o_second_edge_midpoint == '0 && o_first_edge == 2'd0 && o_second_edge == 2'd0)
    `TSED_ASSERT_NEVER(a_bad_edge, i_clk, i_rst_n, o_valid && (o_first_edge == 2'd3 || o_second_edge == 2'd3))
    `TSED_ASSERT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall |=> a_valid)
    `TSED_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

endmodule
